// File: rtl/core/mlp_pkg.sv
`default_nettype none

package mlp_pkg;

	// Defaults for the top-level parameters
	localparam int NODES_DEF      = 3;
	localparam int MAX_LAYERS_DEF = 4;

	// Fixed field widths
	localparam int OPC_W  = 2;
	localparam int IDX_W  = 6;
	localparam int VAL_W  = 16;
	localparam int ACT_W  = 13;
	localparam int LCNT_W = 3;
	localparam int OPND_W = VAL_W + 1;
	localparam int PROD_W = VAL_W + OPND_W;
	localparam int SUM_W  = 40;

	localparam logic [ACT_W-1:0] ACT_ONE = ACT_W'(4096);

	typedef enum logic [OPC_W-1:0] {
		OP_LOAD_W = 2'd0,
		OP_LOAD_F = 2'd1,
		OP_RUN    = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WAIT,
		S_RD,
		S_MUL,
		S_ACC,
		S_SIG
	} seq_state_t;

	typedef struct packed {
		logic clear;
		logic load_a;
		logic mul_en;
		logic acc_en;
	} mac_ctl_t;

	typedef logic [255:0][ACT_W-1:0] sig_table_t;

	// a*b at scale 2^48
	function automatic longint unsigned mul_q48(longint unsigned a, longint unsigned b);
		longint unsigned ah;
		longint unsigned al;
		longint unsigned bh;
		longint unsigned bl;
		ah = a >> 24;
		al = a & 64'hFF_FFFF;
		bh = b >> 24;
		bl = b & 64'hFF_FFFF;
		return ah * bh + ((ah * bl + al * bh) >> 24) + ((al * bl) >> 48);
	endfunction

	// unsigned 64-bit quotient, restoring shift and subtract
	function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
		longint unsigned quo;
		longint unsigned rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = (rem << 1) | ((num >> b) & 64'd1);
			if (rem >= den) begin
				rem = rem - den;
				quo = quo | (64'd1 << b);
			end
		end
		return quo;
	endfunction

	// Sigmoid table, entry j = round(4096/(1+exp(-x))), x = -8 + j/16
	function automatic sig_table_t sig_build();
		sig_table_t      t;
		longint unsigned one;
		longint unsigned term;
		longint unsigned step;
		longint unsigned p;
		longint unsigned d;
		longint unsigned q;
		t    = '0;
		one  = 64'd1 << 48;
		term = one;
		step = one;
		p    = one;
		for (int n = 1; n <= 12; n++) begin
			term = udiv64(term, 64'(16 * n));
			if ((n & 1) == 1)
				step = step - term;
			else
				step = step + term;
		end
		for (int k = 0; k <= 128; k++) begin
			d = one + p;
			if (k <= 127) begin
				q = udiv64((one << 12) + (d >> 1), d);
				t[128 + k] = q[ACT_W-1:0];
			end
			if (k >= 1) begin
				q = udiv64((p << 12) + (d >> 1), d);
				t[128 - k] = q[ACT_W-1:0];
			end
			p = mul_q48(p, step);
		end
		return t;
	endfunction

	localparam sig_table_t SIG_TABLE = sig_build();

endpackage

`default_nettype wire

// File: rtl/core/mlp_req_if.sv
`default_nettype none

interface mlp_req_if
	import mlp_pkg::*;
;
	logic                    valid;
	logic                    ready;
	logic [OPC_W-1:0]        opcode;
	logic [IDX_W-1:0]        index;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, output opcode, output index, output value, input ready);
	modport sink   (input valid, input opcode, input index, input value, output ready);
endinterface

`default_nettype wire

// File: rtl/core/mlp_rsp_if.sv
`default_nettype none

interface mlp_rsp_if
	import mlp_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [ACT_W-1:0] prediction;

	modport source (output valid, output prediction, input ready);
	modport sink   (input valid, input prediction, output ready);
endinterface

`default_nettype wire

// File: rtl/core/mlp_ram.sv
`default_nettype none

module mlp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 36
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/core/mlp_mac.sv
`default_nettype none

// Shared multiply-accumulate with sigmoid lookup on the running sum.
module mlp_mac
	import mlp_pkg::*;
(
	input  wire logic                     clk,
	input  wire mac_ctl_t                 ctl,
	input  wire logic [VAL_W-1:0]         weight,
	input  wire logic signed [OPND_W-1:0] operand,
	output logic      [ACT_W-1:0]         sig
);

	localparam logic signed [SUM_W-1:0] SUM_EIGHT = SUM_W'(134217728);

	logic signed [OPND_W-1:0] a_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [SUM_W-1:0]  acc_q;
	logic signed [SUM_W-1:0]  biased;
	logic [7:0]               tidx;

	always_ff @(posedge clk) begin
		if (ctl.load_a)
			a_q <= operand;
		if (ctl.mul_en)
			prod_q <= $signed(weight) * a_q;
		if (ctl.clear)
			acc_q <= '0;
		else if (ctl.acc_en)
			acc_q <= acc_q + SUM_W'(prod_q);
	end

	// nearest entry below, saturated at both ends
	always_comb begin
		biased = acc_q + SUM_EIGHT;
		if (acc_q < -SUM_EIGHT)
			tidx = 8'd0;
		else if (acc_q >= SUM_EIGHT)
			tidx = 8'd255;
		else
			tidx = biased[27:20];
		sig = SIG_TABLE[tidx];
	end

endmodule

`default_nettype wire

// File: rtl/core/mlp_sigmoid_forward_pass.sv
// Load beats (weight or feature) complete in the beat that accepts them; a run beat is
// accepted and then ready drops until its result sits in the output register.
// Run time is set by the single shared multiply-accumulate unit (read weight, multiply,
// accumulate per term, one sigmoid step per node).
// Async active-low reset clears the sequencer, output valid, activations; layer_count = 2.
`default_nettype none

module mlp_sigmoid_forward_pass
	import mlp_pkg::*;
#(
	parameter int NODES      = NODES_DEF,
	parameter int MAX_LAYERS = MAX_LAYERS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [LCNT_W-1:0] cfg_data,
	mlp_req_if.sink                req,
	mlp_rsp_if.source              rsp
);

	localparam int W_DEPTH = MAX_LAYERS * NODES * NODES;
	localparam int WADDR_W = $clog2(W_DEPTH);
	localparam int NIDX_W  = $clog2(NODES);
	localparam int LIDX_W  = $clog2(MAX_LAYERS);
	localparam int AIDX_W  = $clog2(2 * NODES);

	seq_state_t state_q;
	seq_state_t state_d;

	logic [LCNT_W-1:0] layer_count_q;
	logic [LIDX_W-1:0] last_l;
	logic [LIDX_W-1:0] l_q;
	logic [NIDX_W-1:0] i_q;
	logic [NIDX_W-1:0] k_q;
	logic              last_k;
	logic              last_node;

	logic signed [VAL_W-1:0] feat_q [NODES];
	logic [ACT_W-1:0]        act_q  [2 * NODES];

	logic              in_beat;
	logic              run_beat;
	logic              w_we;
	logic [WADDR_W-1:0] w_waddr;
	logic [WADDR_W-1:0] w_raddr;
	logic [VAL_W-1:0]  w_rdata;

	mac_ctl_t                 mac_ctl;
	logic signed [OPND_W-1:0] operand;
	logic [AIDX_W-1:0]        act_ridx;
	logic [ACT_W-1:0]         sig;

	logic              act_we;
	logic [AIDX_W-1:0] act_widx;
	logic [ACT_W-1:0]  act_wdata;
	logic              out_load;

	logic              out_valid_q;
	logic [ACT_W-1:0]  pred_q;

	// ------------------------------------------------------------------
	// Input side: loads finish in the beat, a run hands off to the sequencer
	// ------------------------------------------------------------------
	assign req.ready = (state_q == S_IDLE);
	assign in_beat   = req.valid && req.ready;
	assign run_beat  = in_beat && (req.opcode == OP_RUN);
	assign w_we      = in_beat && (req.opcode == OP_LOAD_W) && (int'(req.index) < W_DEPTH);
	assign w_waddr   = WADDR_W'(req.index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			layer_count_q <= LCNT_W'(2);
		else if (cfg_we)
			layer_count_q <= cfg_data;
	end

	// Out-of-range counts clamp to 2..MAX_LAYERS; last_l is the output layer.
	always_comb begin
		if (layer_count_q < LCNT_W'(2))
			last_l = LIDX_W'(1);
		else if (int'(layer_count_q) > MAX_LAYERS)
			last_l = LIDX_W'(MAX_LAYERS - 1);
		else
			last_l = LIDX_W'(int'(layer_count_q) - 1);
	end

	always_ff @(posedge clk) begin
		if (in_beat && (req.opcode == OP_LOAD_F) && (int'(req.index) < NODES))
			feat_q[NIDX_W'(req.index)] <= req.value;
	end

	mlp_ram #(
		.WIDTH (VAL_W),
		.DEPTH (W_DEPTH)
	) u_wram (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_waddr),
		.wdata (req.value),
		.raddr (w_raddr),
		.rdata (w_rdata)
	);

	// ------------------------------------------------------------------
	// Sequencer: layer l, node i, term k
	// ------------------------------------------------------------------
	assign last_k    = (k_q == NIDX_W'(NODES - 1));
	assign last_node = (i_q == NIDX_W'(NODES - 1));

	// weight W[l][k][i]
	assign w_raddr = WADDR_W'(int'(l_q) * NODES * NODES + int'(k_q) * NODES + int'(i_q));

	// layer l reads the bank layer l-1 wrote; even layers write bank 0, odd layers bank 1
	assign act_ridx = AIDX_W'((l_q[0] ? 0 : NODES) + int'(k_q));

	always_comb begin
		if (l_q == '0)
			operand = OPND_W'(feat_q[k_q]);
		else
			operand = $signed({{(OPND_W - ACT_W){1'b0}}, act_q[act_ridx]});
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (run_beat) state_d = S_WAIT;
			S_WAIT:  if (!out_valid_q) state_d = S_RD;
			S_RD:    state_d = S_MUL;
			S_MUL:   state_d = S_ACC;
			S_ACC:   state_d = last_k ? S_SIG : S_RD;
			S_SIG:   state_d = (l_q == last_l) ? S_IDLE : S_RD;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		mac_ctl   = '0;
		act_we    = 1'b0;
		act_widx  = AIDX_W'((l_q[0] ? NODES : 0) + int'(i_q));
		act_wdata = sig;
		out_load  = 1'b0;
		case (state_q)
			S_RD: begin
				mac_ctl.load_a = 1'b1;
				mac_ctl.clear  = (k_q == '0);
				// bias node of the layer being built
				if ((l_q != last_l) && (i_q == NIDX_W'(1)) && (k_q == '0)) begin
					act_we    = 1'b1;
					act_widx  = AIDX_W'(l_q[0] ? NODES : 0);
					act_wdata = ACT_ONE;
				end
			end
			S_MUL: mac_ctl.mul_en = 1'b1;
			S_ACC: mac_ctl.acc_en = 1'b1;
			S_SIG: begin
				if (l_q == last_l)
					out_load = 1'b1;
				else
					act_we = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			l_q     <= '0;
			i_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					if (run_beat) begin
						l_q <= '0;
						i_q <= NIDX_W'(1);
						k_q <= '0;
					end
				end
				S_ACC: k_q <= last_k ? '0 : k_q + NIDX_W'(1);
				S_SIG: begin
					if (l_q != last_l) begin
						if (last_node) begin
							l_q <= l_q + LIDX_W'(1);
							// output layer has node 0 only
							i_q <= ((l_q + LIDX_W'(1)) == last_l) ? '0 : NIDX_W'(1);
						end else begin
							i_q <= i_q + NIDX_W'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < 2 * NODES; j++)
				act_q[j] <= '0;
		end else if (act_we) begin
			act_q[act_widx] <= act_wdata;
		end
	end

	mlp_mac u_mac (
		.clk     (clk),
		.ctl     (mac_ctl),
		.weight  (w_rdata),
		.operand (operand),
		.sig     (sig)
	);

	// ------------------------------------------------------------------
	// Output register; a run waits in S_WAIT while it is still full
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (rsp.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load)
			pred_q <= sig;
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.prediction = pred_q;

`ifndef ASSERT_OFF
	a_result_from_sig: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_SIG))
		else $error("result appeared outside the sigmoid step");

	a_run_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		run_beat |=> !req.ready)
		else $error("input still ready after a run beat");

	a_load_no_op: assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && (req.opcode != OP_RUN)) |=> (req.ready && !$rose(out_valid_q)))
		else $error("load beat started work");

	a_pred_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (pred_q <= ACT_ONE))
		else $error("prediction above one");

	a_acc_ctl: assert property (@(posedge clk) disable iff (!arst_n)
		!(mac_ctl.clear && mac_ctl.acc_en) && !(out_load && act_we))
		else $error("conflicting datapath controls");
`endif

endmodule

`default_nettype wire

// File: tb/tb_mlp_sigmoid_forward_pass.sv
`default_nettype none

module tb_mlp_sigmoid_forward_pass;
	import mlp_pkg::*;

	localparam int     NN        = NODES_DEF;
	localparam int     W_DEPTH   = MAX_LAYERS_DEF * NN * NN;
	// longer than the longest run, at four layers, with some slack on top
	localparam int     DRAIN_CYC = 80;
	// long back-pressure window on the result side
	localparam int     HOLD_CYC  = 400;
	// 8.0 at the product scale of 2^24
	localparam longint SIG_SPAN  = 64'sd134217728;

	typedef struct {
		opcode_t                 op;
		logic [IDX_W-1:0]        idx;
		logic signed [VAL_W-1:0] val;
	} net_cmd_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [LCNT_W-1:0] cfg_data;

	mlp_req_if req_bus ();
	mlp_rsp_if rsp_bus ();

	mlp_sigmoid_forward_pass uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.req      (req_bus),
		.rsp      (rsp_bus)
	);

	// Predictor state: own copy of the network memories and the layer count
	logic [ACT_W-1:0]        sig_tbl [256];
	logic signed [VAL_W-1:0] wts [W_DEPTH];
	logic signed [VAL_W-1:0] feats [NN];
	logic [ACT_W-1:0]        acts [2*NN];
	logic [LCNT_W-1:0]       layers_cfg = 3'd2;

	net_cmd_t         cmd_q[$];       // beats waiting to be offered
	net_cmd_t         on_bus;         // beat currently offered on req_bus
	logic [ACT_W-1:0] want_pred[$];   // predictions still owed by the block

	int fail_cnt     = 0;
	int src_gap      = 0;
	int sink_gap     = 0;
	int hold_req     = 0;
	int hold_seen    = 0;
	bit src_idle_en  = 1'b0;
	bit sink_idle_en = 1'b0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("** mlp_sigmoid_forward_pass: FAILED **");
		$finish;
	end

	// ---------------------------------------------------------------
	// Sigmoid table. exp(-1/16) comes from its series; successive powers
	// give sigmoid(+x) = 1/(1+p) and sigmoid(-x) = p/(1+p), all at 2^48.
	// ---------------------------------------------------------------
	function automatic longint unsigned q48_mul(longint unsigned x, longint unsigned y);
		longint unsigned xh, xl, yh, yl;
		xh = x >> 24;
		xl = x & 64'hFF_FFFF;
		yh = y >> 24;
		yl = y & 64'hFF_FFFF;
		return xh * yh + ((xh * yl + xl * yh) >> 24) + ((xl * yl) >> 48);
	endfunction

	function automatic void sig_tbl_fill();
		longint unsigned unity, term, ratio, p, d, q;
		unity = 64'd1 << 48;
		term  = unity;
		ratio = unity;
		p     = unity;
		for (int n = 1; n <= 12; n++) begin
			term  = term / 64'(16 * n);
			ratio = (n % 2 == 1) ? ratio - term : ratio + term;
		end
		for (int k = 0; k <= 128; k++) begin
			d = unity + p;
			if (k < 128) begin
				q = ((unity << 12) + d / 2) / d;
				sig_tbl[128 + k] = q[ACT_W-1:0];
			end
			if (k > 0) begin
				q = ((p << 12) + d / 2) / d;
				sig_tbl[128 - k] = q[ACT_W-1:0];
			end
			p = q48_mul(p, ratio);
		end
	endfunction

	// nearest entry below, clamped to the table ends
	function automatic logic [ACT_W-1:0] sig_of(longint s);
		if (s < -SIG_SPAN)
			return sig_tbl[0];
		if (s >= SIG_SPAN)
			return sig_tbl[255];
		return sig_tbl[int'((s + SIG_SPAN) >>> 20)];
	endfunction

	// Full forward pass; activations ping-pong between two banks of NN
	function automatic logic [ACT_W-1:0] net_eval();
		int     nl, cur, prv;
		longint s, a;
		nl = int'(layers_cfg);
		if (nl < 2)
			nl = 2;
		if (nl > MAX_LAYERS_DEF)
			nl = MAX_LAYERS_DEF;
		cur = 0;
		prv = 0;
		for (int l = 0; l + 1 < nl; l++) begin
			cur = (l % 2) * NN;
			prv = NN - cur;
			acts[cur] = ACT_ONE;   // bias node
			for (int i = 1; i < NN; i++) begin
				s = 0;
				for (int k = 0; k < NN; k++) begin
					a = (l == 0) ? longint'(feats[k]) : longint'(acts[prv + k]);
					s += longint'(wts[l*NN*NN + k*NN + i]) * a;
				end
				acts[cur + i] = sig_of(s);
			end
		end
		s = 0;
		for (int k = 0; k < NN; k++)
			s += longint'(wts[(nl - 1)*NN*NN + k*NN]) * longint'(acts[cur + k]);
		return sig_of(s);
	endfunction

	// Effect of one accepted request beat on the predictor
	function automatic void net_apply(net_cmd_t c);
		case (c.op)
			OP_LOAD_W: begin
				if (c.idx < W_DEPTH)
					wts[c.idx] = c.val;
			end
			OP_LOAD_F: begin
				if (c.idx < NN)
					feats[c.idx] = c.val;
			end
			OP_RUN: begin
				want_pred.push_back(net_eval());
			end
			default: ;   // unknown opcode: ignored
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	function automatic void put(opcode_t op, int idx, logic [VAL_W-1:0] val);
		net_cmd_t c;
		c.op  = op;
		c.idx = IDX_W'(idx);
		c.val = val;
		cmd_q.push_back(c);
	endfunction

	// mostly values that keep the sums inside the table, some full range
	function automatic logic [VAL_W-1:0] mid_val();
		if ($urandom_range(0, 4) == 0)
			return VAL_W'($urandom());
		return VAL_W'($urandom_range(0, 20000) - 10000);
	endfunction

	// mostly back-to-back, sometimes short, rarely long
	function automatic int pick_gap(bit en);
		int r;
		if (!en)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Well-formed groups (a few loads, then a run) plus some noise beats.
	// Ignored beats (unknown opcode, address out of range) are not counted.
	task automatic queue_traffic(input int n);
		int       cnt;
		net_cmd_t c;
		cnt = 0;
		while (cnt < n) begin
			if ($urandom_range(0, 99) < 85) begin
				repeat ($urandom_range(0, 3)) begin
					put(OP_LOAD_W, $urandom_range(0, W_DEPTH - 1), mid_val());
					cnt++;
				end
				repeat ($urandom_range(0, 2)) begin
					put(OP_LOAD_F, $urandom_range(0, NN - 1), mid_val());
					cnt++;
				end
				put(OP_RUN, $urandom_range(0, 63), VAL_W'($urandom()));
				cnt++;
			end else begin
				c.op  = opcode_t'($urandom_range(0, 3));
				c.idx = IDX_W'($urandom_range(0, 63));
				c.val = VAL_W'($urandom());
				cmd_q.push_back(c);
				if (c.op == OP_RUN || (c.op == OP_LOAD_W && c.idx < W_DEPTH) ||
				    (c.op == OP_LOAD_F && c.idx < NN))
					cnt++;
			end
		end
	endtask

	// sender pause: nothing queued, nothing offered, every prediction back
	task automatic wait_drained();
		while (cmd_q.size() != 0 || req_bus.valid || want_pred.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYC) @(negedge clk);
	endtask

	// only called while the block is idle
	task automatic set_layers(input logic [LCNT_W-1:0] lc);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= lc;
		@(posedge clk);
		cfg_we     <= 1'b0;
		layers_cfg = lc;
		@(negedge clk);
	endtask

	// ---------------------------------------------------------------
	// Request driver: offers queued beats, random gaps after each accept
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_bus.valid && req_bus.ready) begin
				net_apply(on_bus);
				src_gap = pick_gap(src_idle_en);
			end
			if (!req_bus.valid || req_bus.ready) begin
				if (src_gap > 0) begin
					src_gap--;
					req_bus.valid <= 1'b0;
				end else if (cmd_q.size() != 0) begin
					on_bus = cmd_q.pop_front();
					req_bus.valid  <= 1'b1;
					req_bus.opcode <= on_bus.op;
					req_bus.index  <= on_bus.idx;
					req_bus.value  <= on_bus.val;
				end else begin
					req_bus.valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Result side ready: random stalls, plus one long hold on request
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				sink_gap  = HOLD_CYC;
			end else if (sink_gap == 0 && sink_idle_en && $urandom_range(0, 99) < 30) begin
				sink_gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4)
				                                      : $urandom_range(10, 40);
			end
			if (sink_gap > 0) begin
				sink_gap--;
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------
	// Result monitor: each beat against the oldest owed prediction
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		logic [ACT_W-1:0] exp_v;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (want_pred.size() == 0) begin
				$error("prediction: expected none, actual %0d", rsp_bus.prediction);
				fail_cnt++;
			end else begin
				exp_v = want_pred.pop_front();
				if (rsp_bus.prediction !== exp_v) begin
					$error("prediction: expected %0d, actual %0d", exp_v, rsp_bus.prediction);
					fail_cnt++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Sequence: reset, preload, directed beats, then random phases, each
	// at its own layer count. Includes out-of-range counts (0, 1, 5..7).
	// ---------------------------------------------------------------
	initial begin
		int plan [9] = '{4, 1, 3, 7, 2, 0, 6, 5, 4};

		sig_tbl_fill();
		foreach (acts[j])
			acts[j] = '0;

		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_data       = '0;
		req_bus.valid  = 1'b0;
		req_bus.opcode = OP_LOAD_W;
		req_bus.index  = '0;
		req_bus.value  = '0;
		rsp_bus.ready  = 1'b0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// every weight and feature written before any run reads them
		for (int j = 0; j < W_DEPTH; j++)
			put(OP_LOAD_W, j, mid_val());
		for (int j = 0; j < NN; j++)
			put(OP_LOAD_F, j, mid_val());

		// directed: default layer count, no idling
		put(OP_RUN, 0, '0);
		// input bias taken as stored, here at its maximum
		put(OP_LOAD_F, 0, 16'h7FFF);
		put(OP_RUN, 0, '0);
		// huge positive sum into node 1: table top entry
		for (int j = 0; j < NN; j++)
			put(OP_LOAD_W, j*NN + 1, 16'h7FFF);
		put(OP_LOAD_F, 1, 16'h7FFF);
		put(OP_LOAD_F, 2, 16'h7FFF);
		put(OP_RUN, 0, '0);
		// most negative features: bottom entry
		for (int j = 0; j < NN; j++)
			put(OP_LOAD_F, j, 16'h8000);
		put(OP_RUN, 0, '0);
		// weight extremes, incl. output layer
		put(OP_LOAD_W, 2, 16'h8000);
		put(OP_LOAD_W, NN*NN, 16'h7FFF);
		put(OP_RUN, 0, '0);
		// unknown opcode must leave the stores alone
		put(OP_NONE, 0, 16'h1234);
		put(OP_RUN, 63, 16'hFFFF);
		// loads past the end of both stores are dropped
		put(OP_LOAD_W, W_DEPTH, 16'h7FFF);
		put(OP_LOAD_W, 63, 16'h8000);
		put(OP_LOAD_F, NN, 16'h7FFF);
		put(OP_LOAD_F, 63, 16'h8000);
		put(OP_RUN, 0, '0);
		wait_drained();

		for (int ph = 0; ph < 9; ph++) begin
			set_layers(LCNT_W'(plan[ph]));
			src_idle_en  <= (ph % 3 != 1);
			sink_idle_en <= (ph % 3 != 2);
			// one phase opens with a long result-side hold so the block backs up
			if (ph == 4)
				hold_req <= hold_req + 1;
			@(negedge clk);
			queue_traffic(48);
			wait_drained();
		end

		if (fail_cnt == 0 && want_pred.size() == 0) begin
			$display("** mlp_sigmoid_forward_pass: PASSED **");
		end else begin
			$display("** mlp_sigmoid_forward_pass: FAILED **");
		end
		$finish;
	end

endmodule

`default_nettype wire
